FILE: sv/ctpb_pkg.sv
// Package for the cycle timer progress bar: command and register codes,
// field widths, reset values and the controller/datapath handshake structs.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ctpb_pkg;

  // Parameter defaults
  localparam int unsigned LED_COUNT_DEF   = 64;
  localparam int unsigned FPS_DEF         = 30;

  // Fixed field and state widths
  localparam int unsigned TARGET_W        = 16;
  localparam int unsigned BRIGHT_W        = 9;
  localparam int unsigned CFG_DATA_W      = 16;
  localparam int unsigned ELAPSED_W       = 20;
  localparam int unsigned FRAME_W         = 5;
  localparam int unsigned BLINK_W         = 4;
  localparam int unsigned LED_INDEX_W     = 6;
  localparam int unsigned COLOR_W         = 8;
  localparam int unsigned S_TDATA_W       = 8;
  localparam int unsigned S_TUSER_W       = 2;
  localparam int unsigned M_TDATA_W       = 32;

  // Reset values and constants
  localparam logic [TARGET_W-1:0] TARGET_RESET = 16'd60;
  localparam logic [BRIGHT_W-1:0] BRIGHT_RESET = 9'd77;
  localparam logic [BRIGHT_W-1:0] BRIGHT_MAX   = 9'd256;
  localparam logic [BLINK_W-1:0]  BLINK_PERIOD = 4'd15;
  localparam logic [COLOR_W-1:0]  COLOR_FULL   = 8'd255;
  localparam logic [COLOR_W-1:0]  COLOR_ORANGE = 8'd80;

  // Input command codes (s_axis_tuser)
  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_START = 2'd1,
    CMD_ACK   = 2'd2,
    CMD_STOP  = 2'd3
  } cmd_e;

  // Configuration register indexes
  typedef enum logic [0:0] {
    CFG_TARGET = 1'b0,
    CFG_BRIGHT = 1'b1
  } cfg_index_e;

  // What an accepted transaction asks of the sequencer
  typedef enum logic [1:0] {
    KIND_NONE  = 2'd0,
    KIND_FRAME = 2'd1,
    KIND_TIMER = 2'd2
  } kind_e;

  // Controller to datapath
  typedef struct packed {
    logic accept;
    logic calc;
    logic decide;
    logic div_step;
    logic emit_load;
  } ctl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    kind_e kind;
    logic  over;
    logic  pix_last;
    logic  out_free;
  } ctl_status_t;

endpackage

`default_nettype wire

FILE: sv/cycle_timer_progress_bar_unit.sv
// Top level of the cycle timer progress bar: sequencer plus datapath.
// Depends on ctpb_pkg, ctpb_ctrl and ctpb_datapath.
//
//  channel  | direction | payload
//  ---------+-----------+---------------------------------------------------
//  s_axis   | in        | tuser: cmd; tdata: preview, work_mode
//  m_axis   | out       | tdata: led_index, green, red, blue, buzzer, alarm;
//           |           | tlast: last pixel of the frame
//  cfg      | in        | write only: 0 cycle_target_seconds, 1 brightness
//
// Start, acknowledge and stop are applied on acceptance. A preview tick or a
// dark frame goes straight to pixel emission; a timer tick first passes
// through the timer math and the one-bit-per-cycle divider, then emits one
// pixel per cycle through the output register; an overrun tick skips the
// divider. An output stall holds the pixel sequencer; s_axis_tready_o is
// high only while the sequencer is idle. Reset is asynchronous and needs no
// clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module cycle_timer_progress_bar_unit #(
  parameter int unsigned LED_COUNT         = ctpb_pkg::LED_COUNT_DEF,
  parameter int unsigned FRAMES_PER_SECOND = ctpb_pkg::FPS_DEF
) (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  wire                              s_axis_tvalid_i,
  output logic                             s_axis_tready_o,
  input  wire  [ctpb_pkg::S_TDATA_W-1:0]   s_axis_tdata_i,  // [0] preview, [1] work_mode
  input  wire  [ctpb_pkg::S_TUSER_W-1:0]   s_axis_tuser_i,  // [1:0] cmd
  output logic                             m_axis_tvalid_o,
  input  wire                              m_axis_tready_i,
  // [5:0] led_index, [13:6] green, [21:14] red, [29:22] blue,
  // [30] buzzer, [31] alarm_active
  output logic [ctpb_pkg::M_TDATA_W-1:0]   m_axis_tdata_o,
  output logic                             m_axis_tlast_o,
  input  wire                              cfg_we_i,
  input  wire                              cfg_index_i,
  input  wire  [ctpb_pkg::CFG_DATA_W-1:0]  cfg_wdata_i
);

  ctpb_pkg::ctl_cmd_t    ctl_cmd;
  ctpb_pkg::ctl_status_t ctl_status;

  ctpb_ctrl #(
    .LED_COUNT (LED_COUNT)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid_i),
    .s_tready_o (s_axis_tready_o),
    .status_i   (ctl_status),
    .cmd_o      (ctl_cmd)
  );

  ctpb_datapath #(
    .LED_COUNT         (LED_COUNT),
    .FRAMES_PER_SECOND (FRAMES_PER_SECOND)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s_tdata_i   (s_axis_tdata_i),
    .s_tuser_i   (s_axis_tuser_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cmd_i       (ctl_cmd),
    .status_o    (ctl_status),
    .m_tready_i  (m_axis_tready_i),
    .m_tvalid_o  (m_axis_tvalid_o),
    .m_tdata_o   (m_axis_tdata_o),
    .m_tlast_o   (m_axis_tlast_o)
  );

  // The sequencer issues at most one command per cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(ctl_cmd))
    else $error("controller issued overlapping commands");

  // The last pixel of a frame is the highest LED position
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tlast_o) |->
      (m_axis_tdata_o[ctpb_pkg::LED_INDEX_W-1:0] ==
       ctpb_pkg::LED_INDEX_W'(LED_COUNT - 1)))
    else $error("tlast on a pixel other than the last");

  // The buzzer only sounds while the alarm is active
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tdata_o[30]) |-> m_axis_tdata_o[31])
    else $error("buzzer on without an active alarm");

  // No new transaction is taken while pixels are being loaded
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_cmd.emit_load |-> !s_axis_tready_o)
    else $error("input ready during frame emission");

endmodule

`default_nettype wire

FILE: sv/ctpb_ctrl.sv
// Sequencer of the progress bar: accept, timer math, divide steps, pixel emit.
// Depends on ctpb_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ctpb_ctrl #(
  parameter int unsigned LED_COUNT = ctpb_pkg::LED_COUNT_DEF
) (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  wire                    s_tvalid_i,
  output logic                   s_tready_o,
  input  ctpb_pkg::ctl_status_t  status_i,
  output ctpb_pkg::ctl_cmd_t     cmd_o
);

  localparam int unsigned QW   = $clog2(LED_COUNT + 1);
  localparam int unsigned STEP_W = $clog2(QW);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CALC,
    ST_DECIDE,
    ST_DIV,
    ST_EMIT
  } state_e;

  state_e            state_q;
  logic [STEP_W-1:0] step_q;

  // Decode commands from the current state
  always_comb begin
    cmd_o           = '0;
    s_tready_o      = (state_q == ST_IDLE);
    cmd_o.accept    = (state_q == ST_IDLE) && s_tvalid_i;
    cmd_o.calc      = (state_q == ST_CALC);
    cmd_o.decide    = (state_q == ST_DECIDE);
    cmd_o.div_step  = (state_q == ST_DIV);
    cmd_o.emit_load = (state_q == ST_EMIT) && status_i.out_free;
  end

  // Advance the sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= '0;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (s_tvalid_i) begin
            unique case (status_i.kind)
              ctpb_pkg::KIND_FRAME: state_q <= ST_EMIT;
              ctpb_pkg::KIND_TIMER: state_q <= ST_CALC;
              default:              state_q <= ST_IDLE;
            endcase
          end
        end
        ST_CALC: state_q <= ST_DECIDE;
        ST_DECIDE: begin
          if (status_i.over) begin
            state_q <= ST_EMIT;
          end else begin
            state_q <= ST_DIV;
            step_q  <= STEP_W'(QW - 1);
          end
        end
        ST_DIV: begin
          if (step_q == '0) begin
            state_q <= ST_EMIT;
          end else begin
            step_q <= step_q - 1'b1;
          end
        end
        ST_EMIT: begin
          if (status_i.out_free && status_i.pix_last) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: sv/ctpb_datapath.sv
// Datapath of the progress bar: config registers, cycle timer, alarm blink,
// fill divider, pixel coloring and the output register. Depends on ctpb_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ctpb_datapath #(
  parameter int unsigned LED_COUNT         = ctpb_pkg::LED_COUNT_DEF,
  parameter int unsigned FRAMES_PER_SECOND = ctpb_pkg::FPS_DEF
) (
  input  wire                                 clk_i,
  input  wire                                 rst_ni,
  input  wire  [ctpb_pkg::S_TDATA_W-1:0]      s_tdata_i,
  input  wire  [ctpb_pkg::S_TUSER_W-1:0]      s_tuser_i,
  input  wire                                 cfg_we_i,
  input  wire                                 cfg_index_i,
  input  wire  [ctpb_pkg::CFG_DATA_W-1:0]     cfg_wdata_i,
  input  ctpb_pkg::ctl_cmd_t                  cmd_i,
  output ctpb_pkg::ctl_status_t               status_o,
  input  wire                                 m_tready_i,
  output logic                                m_tvalid_o,
  output logic [ctpb_pkg::M_TDATA_W-1:0]      m_tdata_o,
  output logic                                m_tlast_o
);

  localparam int unsigned FW          = $clog2(FRAMES_PER_SECOND + 1);
  localparam int unsigned QW          = $clog2(LED_COUNT + 1);
  localparam int unsigned NUM_W       = ctpb_pkg::ELAPSED_W + FW;
  localparam int unsigned DEN_W       = ctpb_pkg::TARGET_W + FW;
  localparam int unsigned DW          = DEN_W + QW;
  localparam int unsigned IW          = ctpb_pkg::LED_INDEX_W + 1;
  localparam int unsigned ORANGE_FROM = LED_COUNT * 7 / 10;
  localparam int unsigned RED_FROM    = LED_COUNT * 9 / 10;
  localparam int unsigned PROD_W      = ctpb_pkg::BRIGHT_W + ctpb_pkg::COLOR_W;

  // Configuration and timer state
  logic [ctpb_pkg::TARGET_W-1:0]    target_q;
  logic [ctpb_pkg::BRIGHT_W-1:0]    bright_q;
  logic                             running_q;
  logic [ctpb_pkg::ELAPSED_W-1:0]   elapsed_q;
  logic [ctpb_pkg::FRAME_W-1:0]     frame_q;
  logic [ctpb_pkg::BLINK_W-1:0]     blink_cnt_q;
  logic                             blink_on_q;
  logic                             lit_q;
  logic                             ack_q;
  logic                             alarm_q;

  // Frame math
  logic [NUM_W-1:0]                 num_q;
  logic [DEN_W-1:0]                 den_q;
  logic [DW-1:0]                    rem_q;
  logic [DW-1:0]                    dsh_q;
  logic [QW-1:0]                    fill_q;
  logic                             buz_q;
  logic [ctpb_pkg::LED_INDEX_W-1:0] pix_q;

  // Output register
  logic                             ovalid_q;
  logic [ctpb_pkg::M_TDATA_W-1:0]   odata_q;
  logic                             olast_q;

  ctpb_pkg::cmd_e                   in_cmd;
  ctpb_pkg::kind_e                  in_kind;
  logic                             in_preview;
  logic                             in_work;
  logic [ctpb_pkg::FRAME_W-1:0]     frame_inc;
  logic [ctpb_pkg::BLINK_W-1:0]     blink_inc;
  logic                             blink_wrap;
  logic                             blink_next;
  logic                             over;
  logic [DEN_W-1:0]                 num_lim;
  logic                             div_ge;
  logic [ctpb_pkg::LED_INDEX_W-1:0] idx;
  logic                             pix_lit;
  logic [PROD_W-1:0]                prod_full;
  logic [PROD_W-1:0]                prod_orange;
  logic [ctpb_pkg::COLOR_W-1:0]     sc_full;
  logic [ctpb_pkg::COLOR_W-1:0]     sc_orange;
  logic [ctpb_pkg::COLOR_W-1:0]     px_green;
  logic [ctpb_pkg::COLOR_W-1:0]     px_red;

  assign in_cmd     = ctpb_pkg::cmd_e'(s_tuser_i);
  assign in_preview = s_tdata_i[0];
  assign in_work    = s_tdata_i[1];

  // Classify the offered transaction for the sequencer
  always_comb begin
    if (in_cmd != ctpb_pkg::CMD_TICK) begin
      in_kind = ctpb_pkg::KIND_NONE;
    end else if (in_preview) begin
      in_kind = ctpb_pkg::KIND_FRAME;
    end else if (running_q) begin
      in_kind = ctpb_pkg::KIND_TIMER;
    end else if (lit_q) begin
      in_kind = ctpb_pkg::KIND_FRAME;
    end else begin
      in_kind = ctpb_pkg::KIND_NONE;
    end
  end

  assign frame_inc  = frame_q + 1'b1;
  assign blink_inc  = blink_cnt_q + 1'b1;
  assign blink_wrap = (blink_inc >= ctpb_pkg::BLINK_PERIOD);
  assign blink_next = blink_wrap ? !blink_on_q : blink_on_q;
  assign over       = (num_q > NUM_W'(den_q)) && !ack_q;
  assign div_ge     = (rem_q >= dsh_q);

  // A numerator at or past the target gives a full bar; clip it to the target
  assign num_lim    = (num_q >= NUM_W'(den_q)) ? den_q : num_q[DEN_W-1:0];

  assign status_o.kind     = in_kind;
  assign status_o.over     = over;
  assign status_o.pix_last = (pix_q == ctpb_pkg::LED_INDEX_W'(LED_COUNT - 1));
  assign status_o.out_free = !ovalid_q || m_tready_i;

  // Hold config registers; clamp target and brightness on write
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q <= ctpb_pkg::TARGET_RESET;
      bright_q <= ctpb_pkg::BRIGHT_RESET;
    end else if (cfg_we_i) begin
      unique case (ctpb_pkg::cfg_index_e'(cfg_index_i))
        ctpb_pkg::CFG_TARGET: begin
          target_q <= (cfg_wdata_i[ctpb_pkg::TARGET_W-1:0] == '0) ?
                      ctpb_pkg::TARGET_W'(1) : cfg_wdata_i[ctpb_pkg::TARGET_W-1:0];
        end
        ctpb_pkg::CFG_BRIGHT: begin
          bright_q <= (cfg_wdata_i[ctpb_pkg::BRIGHT_W-1:0] > ctpb_pkg::BRIGHT_MAX) ?
                      ctpb_pkg::BRIGHT_MAX : cfg_wdata_i[ctpb_pkg::BRIGHT_W-1:0];
        end
        default: ;
      endcase
    end
  end

  // Apply commands, advance the timer, blink and divide
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      running_q   <= 1'b0;
      elapsed_q   <= '0;
      frame_q     <= '0;
      blink_cnt_q <= '0;
      blink_on_q  <= 1'b1;
      lit_q       <= 1'b0;
      ack_q       <= 1'b0;
      alarm_q     <= 1'b0;
      fill_q      <= '0;
      buz_q       <= 1'b0;
    end else begin
      if (cmd_i.accept) begin
        unique case (in_cmd)
          ctpb_pkg::CMD_START: begin
            elapsed_q <= '0;
            frame_q   <= '0;
            running_q <= 1'b1;
            alarm_q   <= 1'b0;
            ack_q     <= 1'b0;
          end
          ctpb_pkg::CMD_ACK: begin
            ack_q   <= 1'b1;
            alarm_q <= 1'b0;
          end
          ctpb_pkg::CMD_STOP: running_q <= 1'b0;
          ctpb_pkg::CMD_TICK: begin
            if (in_preview) begin
              lit_q  <= 1'b1;
              fill_q <= QW'(LED_COUNT);
              buz_q  <= 1'b0;
            end else if (running_q) begin
              lit_q <= 1'b1;
              if (in_work) begin
                if (frame_inc >= ctpb_pkg::FRAME_W'(FRAMES_PER_SECOND)) begin
                  frame_q <= '0;
                  if (elapsed_q != '1) begin
                    elapsed_q <= elapsed_q + 1'b1;
                  end
                end else begin
                  frame_q <= frame_inc;
                end
              end
            end else if (lit_q) begin
              lit_q  <= 1'b0;
              fill_q <= '0;
              buz_q  <= 1'b0;
            end
          end
          default: ;
        endcase
      end

      // Overrun blinks the whole bar; otherwise clear fill for the divider
      if (cmd_i.decide) begin
        if (over) begin
          alarm_q     <= 1'b1;
          blink_cnt_q <= blink_wrap ? '0 : blink_inc;
          blink_on_q  <= blink_next;
          fill_q      <= blink_next ? QW'(LED_COUNT) : '0;
          buz_q       <= blink_next;
        end else begin
          alarm_q <= 1'b0;
          fill_q  <= '0;
          buz_q   <= 1'b0;
        end
      end

      // Shift in one quotient bit
      if (cmd_i.div_step) begin
        fill_q <= {fill_q[QW-2:0], div_ge};
      end
    end
  end

  // Timer products and the restoring divider operands
  always_ff @(posedge clk_i) begin
    if (cmd_i.calc) begin
      num_q <= NUM_W'(elapsed_q) * NUM_W'(FRAMES_PER_SECOND) + NUM_W'(frame_q);
      den_q <= DEN_W'(target_q) * DEN_W'(FRAMES_PER_SECOND);
    end
    if (cmd_i.decide) begin
      rem_q <= DW'(num_lim) * DW'(LED_COUNT);
      dsh_q <= DW'(den_q) << (QW - 1);
    end else if (cmd_i.div_step) begin
      if (div_ge) begin
        rem_q <= rem_q - dsh_q;
      end
      dsh_q <= dsh_q >> 1;
    end
  end

  // Color the current pixel; logical order runs opposite to the strip
  assign idx         = ctpb_pkg::LED_INDEX_W'(LED_COUNT - 1) - pix_q;
  assign pix_lit     = IW'(idx) < IW'(fill_q);
  assign prod_full   = PROD_W'(ctpb_pkg::COLOR_FULL) * PROD_W'(bright_q);
  assign prod_orange = PROD_W'(ctpb_pkg::COLOR_ORANGE) * PROD_W'(bright_q);
  assign sc_full     = prod_full[15:8];
  assign sc_orange   = prod_orange[15:8];

  always_comb begin
    px_green = '0;
    px_red   = '0;
    if (pix_lit) begin
      if (IW'(idx) < IW'(ORANGE_FROM)) begin
        px_green = sc_full;
      end else if (IW'(idx) < IW'(RED_FROM)) begin
        px_green = sc_orange;
        px_red   = sc_full;
      end else begin
        px_red = sc_full;
      end
    end
  end

  // Pixel counter wraps after the last pixel of a frame
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pix_q <= '0;
    end else if (cmd_i.emit_load) begin
      pix_q <= status_o.pix_last ? '0 : pix_q + 1'b1;
    end
  end

  // Output register: load a pixel when free, drop valid once taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovalid_q <= 1'b0;
    end else if (cmd_i.emit_load) begin
      ovalid_q <= 1'b1;
    end else if (m_tready_i) begin
      ovalid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_load) begin
      odata_q <= {alarm_q, buz_q, ctpb_pkg::COLOR_W'(0), px_red, px_green, pix_q};
      olast_q <= status_o.pix_last;
    end
  end

  assign m_tvalid_o = ovalid_q;
  assign m_tdata_o  = odata_q;
  assign m_tlast_o  = olast_q;

endmodule

`default_nettype wire

FILE: test/tb_cycle_timer_progress_bar_unit.sv
// Self-checking testbench for cycle_timer_progress_bar_unit: predicts every
// pixel of every rendered frame and checks the output stream against it.
// Depends on ctpb_pkg and the cycle_timer_progress_bar_unit RTL.
`timescale 1ns / 1ps

module tb_cycle_timer_progress_bar_unit;

  localparam int unsigned LED_N        = ctpb_pkg::LED_COUNT_DEF;
  localparam int unsigned FPS          = ctpb_pkg::FPS_DEF;
  localparam int unsigned ORANGE_FROM  = (LED_N * 7) / 10;
  localparam int unsigned RED_FROM     = (LED_N * 9) / 10;
  localparam int unsigned SETTLE_CYC   = 100;
  localparam int unsigned LONG_HOLD    = 400;
  localparam int unsigned RANDOM_ITEMS = 70;
  localparam int unsigned LIMIT_CYC    = 800000;
  localparam int unsigned REPORT_MAX   = 50;

  typedef struct {
    logic [ctpb_pkg::LED_INDEX_W-1:0] led_index;
    logic [ctpb_pkg::COLOR_W-1:0]     green;
    logic [ctpb_pkg::COLOR_W-1:0]     red;
    logic [ctpb_pkg::COLOR_W-1:0]     blue;
    logic                             buzzer;
    logic                             alarm_active;
    logic                             frame_end;
  } pixel_t;

  // DUT connections, all known from time zero
  logic                            clk_i = 1'b0;
  logic                            rst_n = 1'b0;
  logic                            s_valid = 1'b0;
  logic [ctpb_pkg::S_TDATA_W-1:0]  s_data = '0;
  logic [ctpb_pkg::S_TUSER_W-1:0]  s_user = '0;
  logic                            m_ready = 1'b0;
  logic                            cfg_we = 1'b0;
  logic                            cfg_idx = 1'b0;
  logic [ctpb_pkg::CFG_DATA_W-1:0] cfg_data = '0;
  wire                             s_axis_tready_o;
  wire                             m_axis_tvalid_o;
  wire  [ctpb_pkg::M_TDATA_W-1:0]  m_axis_tdata_o;
  wire                             m_axis_tlast_o;

  // Bar model state and register copies
  logic                           bar_running   = 1'b0;
  logic [ctpb_pkg::ELAPSED_W-1:0] bar_elapsed   = '0;
  logic [ctpb_pkg::FRAME_W-1:0]   bar_frame     = '0;
  logic [ctpb_pkg::BLINK_W-1:0]   bar_blink_cnt = '0;
  logic                           bar_blink_on  = 1'b1;
  logic                           bar_lit       = 1'b0;
  logic                           bar_acked     = 1'b0;
  logic                           bar_alarm     = 1'b0;
  logic [ctpb_pkg::TARGET_W-1:0]  cfg_target    = ctpb_pkg::TARGET_RESET;
  logic [ctpb_pkg::BRIGHT_W-1:0]  cfg_bright    = ctpb_pkg::BRIGHT_RESET;

  pixel_t      pixel_q[$];
  int unsigned mismatch_cnt = 0;
  int unsigned cycle_cnt = 0;
  int unsigned burst_left = 0;
  int unsigned hold_requests = 0;
  int unsigned hold_served = 0;
  int unsigned hold_left = 0;
  int unsigned rx_mode = 0;
  int unsigned seg_left = 0;

  cycle_timer_progress_bar_unit dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_data),
    .s_axis_tuser_i  (s_user),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o),
    .cfg_we_i        (cfg_we),
    .cfg_index_i     (cfg_idx),
    .cfg_wdata_i     (cfg_data)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // Scale one color byte by the brightness fraction
  function automatic logic [ctpb_pkg::COLOR_W-1:0] scale_color(int unsigned c);
    return ctpb_pkg::COLOR_W'((c * cfg_bright) >> 8);
  endfunction

  // Queue one frame of expected pixels with 'filled' logical pixels lit
  function automatic void queue_frame(int unsigned filled, bit buz);
    pixel_t      px;
    int unsigned pos;
    int unsigned r;
    int unsigned g;
    for (int unsigned k = 0; k < LED_N; k++) begin
      pos = LED_N - 1 - k;
      r = 0;
      g = 0;
      if (pos < filled) begin
        if (pos < ORANGE_FROM) begin
          g = ctpb_pkg::COLOR_FULL;
        end else if (pos < RED_FROM) begin
          r = ctpb_pkg::COLOR_FULL;
          g = ctpb_pkg::COLOR_ORANGE;
        end else begin
          r = ctpb_pkg::COLOR_FULL;
        end
      end
      px.led_index    = ctpb_pkg::LED_INDEX_W'(k);
      px.green        = scale_color(g);
      px.red          = scale_color(r);
      px.blue         = scale_color(0);
      px.buzzer       = buz;
      px.alarm_active = bar_alarm;
      px.frame_end    = (k == LED_N - 1);
      pixel_q.push_back(px);
    end
  endfunction

  // Advance the bar model by one accepted command and queue its pixels
  function automatic void step_bar_model(ctpb_pkg::cmd_e cmd, bit preview, bit work);
    longint unsigned num;
    longint unsigned den;
    longint unsigned fill;
    case (cmd)
      ctpb_pkg::CMD_START: begin
        bar_elapsed = '0;
        bar_frame   = '0;
        bar_running = 1'b1;
        bar_alarm   = 1'b0;
        bar_acked   = 1'b0;
      end
      ctpb_pkg::CMD_ACK: begin
        bar_acked = 1'b1;
        bar_alarm = 1'b0;
      end
      ctpb_pkg::CMD_STOP: bar_running = 1'b0;
      default: begin
        if (preview) begin
          bar_lit = 1'b1;
          queue_frame(LED_N, 1'b0);
        end else if (bar_running) begin
          bar_lit = 1'b1;
          if (work) begin
            bar_frame = bar_frame + 1'b1;
            if (bar_frame >= FPS) begin
              if (bar_elapsed != '1) bar_elapsed = bar_elapsed + 1'b1;
              bar_frame = '0;
            end
          end
          num = longint'(bar_elapsed) * FPS + bar_frame;
          den = longint'(cfg_target) * FPS;
          if (num > den && !bar_acked) begin
            bar_alarm = 1'b1;
            bar_blink_cnt = bar_blink_cnt + 1'b1;
            if (bar_blink_cnt >= ctpb_pkg::BLINK_PERIOD) begin
              bar_blink_on  = !bar_blink_on;
              bar_blink_cnt = '0;
            end
            if (bar_blink_on) queue_frame(LED_N, 1'b1);
            else queue_frame(0, 1'b0);
          end else begin
            fill = num * LED_N / den;
            if (fill > LED_N) fill = LED_N;
            bar_alarm = 1'b0;
            queue_frame(int'(fill), 1'b0);
          end
        end else if (bar_lit) begin
          bar_lit = 1'b0;
          queue_frame(0, 1'b0);
        end
      end
    endcase
  endfunction

  // Offer one command; keep tvalid up inside a burst, drop it for a gap
  task automatic send_command(input ctpb_pkg::cmd_e cmd, input bit preview,
                              input bit work);
    int unsigned gap;
    s_valid <= 1'b1;
    s_user  <= cmd;
    s_data  <= {{(ctpb_pkg::S_TDATA_W-2){1'b0}}, work, preview};
    do @(posedge clk_i); while (!s_axis_tready_o);
    step_bar_model(cmd, preview, work);
    if (burst_left != 0) begin
      burst_left--;
    end else begin
      gap = $urandom_range(1, 120);
      s_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? 15 : $urandom_range(0, 6);
    end
  endtask

  // Write one register; the block must be idle
  task automatic set_register(input ctpb_pkg::cfg_index_e idx,
                              input logic [ctpb_pkg::CFG_DATA_W-1:0] value);
    logic [ctpb_pkg::BRIGHT_W-1:0] b;
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= value;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    if (idx == ctpb_pkg::CFG_TARGET) begin
      cfg_target = (value == '0) ? ctpb_pkg::TARGET_W'(1) : value[ctpb_pkg::TARGET_W-1:0];
    end else begin
      b = value[ctpb_pkg::BRIGHT_W-1:0];
      cfg_bright = (b > ctpb_pkg::BRIGHT_MAX) ? ctpb_pkg::BRIGHT_MAX : b;
    end
    @(posedge clk_i);
  endtask

  // Drop tvalid, wait until every expected pixel has arrived, then settle
  task automatic wait_bar_idle();
    if (s_valid) s_valid <= 1'b0;
    @(posedge clk_i);
    while (pixel_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYC) @(posedge clk_i);
  endtask

  // Idle ticks, preview, dark frame and the non-tick commands out of reset
  task automatic test_idle_and_preview();
    send_command(ctpb_pkg::CMD_TICK, 1'b0, 1'b1);
    send_command(ctpb_pkg::CMD_TICK, 1'b1, 1'b0);
    send_command(ctpb_pkg::CMD_TICK, 1'b0, 1'b0);
    send_command(ctpb_pkg::CMD_TICK, 1'b0, 1'b1);
    send_command(ctpb_pkg::CMD_ACK, 1'b1, 1'b1);
    send_command(ctpb_pkg::CMD_STOP, 1'b0, 1'b0);
    wait_bar_idle();
  endtask

  // Zero target, saturated, zero and near-full brightness
  task automatic test_register_extremes();
    set_register(ctpb_pkg::CFG_TARGET, '0);
    set_register(ctpb_pkg::CFG_BRIGHT, 16'hFFFF);
    send_command(ctpb_pkg::CMD_TICK, 1'b1, 1'b1);
    wait_bar_idle();
    set_register(ctpb_pkg::CFG_BRIGHT, '0);
    send_command(ctpb_pkg::CMD_TICK, 1'b1, 1'b0);
    wait_bar_idle();
    set_register(ctpb_pkg::CFG_BRIGHT, 16'd255);
    send_command(ctpb_pkg::CMD_TICK, 1'b1, 1'b1);
    wait_bar_idle();
  endtask

  // Frozen and advancing timer, preview while running, ack, stop, dark frame
  task automatic test_fill_sequence();
    set_register(ctpb_pkg::CFG_TARGET, 16'd1);
    set_register(ctpb_pkg::CFG_BRIGHT, 16'd256);
    send_command(ctpb_pkg::CMD_START, 1'b0, 1'b0);
    send_command(ctpb_pkg::CMD_TICK, 1'b0, 1'b0);
    send_command(ctpb_pkg::CMD_TICK, 1'b0, 1'b1);
    send_command(ctpb_pkg::CMD_TICK, 1'b1, 1'b1);
    send_command(ctpb_pkg::CMD_TICK, 1'b0, 1'b1);
    send_command(ctpb_pkg::CMD_ACK, 1'b0, 1'b0);
    send_command(ctpb_pkg::CMD_STOP, 1'b1, 1'b0);
    send_command(ctpb_pkg::CMD_TICK, 1'b0, 1'b0);
    send_command(ctpb_pkg::CMD_TICK, 1'b0, 1'b1);
    send_command(ctpb_pkg::CMD_START, 1'b1, 1'b1);
    wait_bar_idle();
  endtask

  // Receiver holds off while the sender keeps offering ticks
  task automatic test_output_backpressure();
    hold_requests++;
    send_command(ctpb_pkg::CMD_TICK, 1'b0, 1'b1);
    send_command(ctpb_pkg::CMD_TICK, 1'b1, 1'b0);
    send_command(ctpb_pkg::CMD_TICK, 1'b0, 1'b1);
    send_command(ctpb_pkg::CMD_TICK, 1'b0, 1'b1);
    wait_bar_idle();
  endtask

  // Timed cycles with random content under random register settings
  task automatic test_random_cycles();
    int unsigned sent;
    int unsigned phase;
    int unsigned len;
    int unsigned r;
    bit          pv;
    bit          wk;
    logic [ctpb_pkg::CFG_DATA_W-1:0] tgt;
    logic [ctpb_pkg::CFG_DATA_W-1:0] br;
    sent = 0;
    phase = 0;
    while (sent < RANDOM_ITEMS) begin
      wait_bar_idle();
      case ($urandom_range(0, 5))
        0: tgt = '0;
        1, 2: tgt = 16'd1;
        3: tgt = 16'd2;
        4: tgt = ctpb_pkg::CFG_DATA_W'($urandom_range(1, 65535));
        default: tgt = 16'hFFFF;
      endcase
      if (phase == 0) tgt = 16'd1;
      case ($urandom_range(0, 5))
        0: br = '0;
        1: br = 16'd256;
        2: br = 16'd255;
        3: br = ctpb_pkg::CFG_DATA_W'($urandom_range(257, 511));
        4: br = ctpb_pkg::CFG_DATA_W'($urandom_range(0, 256));
        default: br = ctpb_pkg::CFG_DATA_W'($urandom);
      endcase
      set_register(ctpb_pkg::CFG_TARGET, tgt);
      set_register(ctpb_pkg::CFG_BRIGHT, br);
      if ($urandom_range(0, 9) != 0) begin
        pv = 1'($urandom_range(0, 1));
        wk = 1'($urandom_range(0, 1));
        send_command(ctpb_pkg::CMD_START, pv, wk);
        sent++;
      end
      len = (phase == 0) ? 60 : $urandom_range(20, 35);
      repeat (len) begin
        r  = $urandom_range(0, 99);
        pv = 1'($urandom_range(0, 1));
        wk = 1'($urandom_range(0, 1));
        if (r < 3) send_command(ctpb_pkg::CMD_ACK, pv, wk);
        else if (r < 5) send_command(ctpb_pkg::CMD_STOP, pv, wk);
        else if (r < 7) send_command(ctpb_pkg::CMD_START, pv, wk);
        else if (r < 12) send_command(ctpb_pkg::CMD_TICK, 1'b1, wk);
        else send_command(ctpb_pkg::CMD_TICK, 1'b0, $urandom_range(0, 9) != 0);
      end
      sent += len;
      phase++;
    end
    wait_bar_idle();
  endtask

  // Drive the receiver ready on changing patterns, with long holds on request
  always @(posedge clk_i) begin
    if (hold_left != 0) begin
      hold_left--;
      m_ready <= 1'b0;
    end else if (hold_requests != hold_served) begin
      hold_served++;
      hold_left = LONG_HOLD;
      m_ready <= 1'b0;
    end else begin
      if (seg_left == 0) begin
        rx_mode  = $urandom_range(0, 3);
        seg_left = $urandom_range(16, 256);
      end
      seg_left--;
      case (rx_mode)
        0: m_ready <= 1'b1;
        1: m_ready <= 1'($urandom_range(0, 1));
        2: m_ready <= (seg_left % 4 == 0);
        default: m_ready <= ($urandom_range(0, 7) != 0);
      endcase
    end
  end

  function automatic void check_field(string name, int unsigned exp_v, int unsigned act_v);
    if (exp_v != act_v) begin
      mismatch_cnt++;
      if (mismatch_cnt <= REPORT_MAX)
        $error("%s: expected %0d, actual %0d", name, exp_v, act_v);
    end
  endfunction

  // Compare each output transaction with the oldest expected pixel
  always @(posedge clk_i) begin
    pixel_t px;
    if (rst_n && m_axis_tvalid_o && m_ready) begin
      if (pixel_q.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= REPORT_MAX)
          $error("unexpected pixel at led_index %0d", m_axis_tdata_o[5:0]);
      end else begin
        px = pixel_q.pop_front();
        check_field("led_index", px.led_index, m_axis_tdata_o[5:0]);
        check_field("green", px.green, m_axis_tdata_o[13:6]);
        check_field("red", px.red, m_axis_tdata_o[21:14]);
        check_field("blue", px.blue, m_axis_tdata_o[29:22]);
        check_field("buzzer", px.buzzer, m_axis_tdata_o[30]);
        check_field("alarm_active", px.alarm_active, m_axis_tdata_o[31]);
        check_field("last", px.frame_end, m_axis_tlast_o);
      end
    end
  end

  // Watchdog on the whole run
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > LIMIT_CYC) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    repeat (11) @(posedge clk_i);
    rst_n <= 1'b1;
    repeat (4) @(posedge clk_i);
    test_idle_and_preview();
    test_register_extremes();
    test_fill_sequence();
    test_output_backpressure();
    test_random_cycles();
    if (mismatch_cnt == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
